// ----- src/tlbf_pkg.sv -----
// Shared types and constants for the fully associative translation buffer.
// Used by the channel interface instances and the top level; no dependencies.
`default_nettype none

package tlbf_pkg;

  localparam int ACTION_W = 2;
  localparam int PAGE_W   = 20;
  localparam int OFF_W    = 12;
  localparam int ADDR_W   = 32;
  localparam int CNT_W    = 32;

  localparam int ENTRIES_DEFAULT    = 64;
  localparam int PAGE_BYTES_DEFAULT = 4096;
  localparam int PAGE_BITS_DEFAULT  = 20;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_FILL   = 2'd1,
    ACT_INVAL  = 2'd2
  } action_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [PAGE_W-1:0]   virt_page;
    logic [OFF_W-1:0]    page_offset;
    logic [PAGE_W-1:0]   phys_page;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] phys_addr;
    logic [CNT_W-1:0]  access_count;
    logic [CNT_W-1:0]  miss_count;
  } rsp_t;

endpackage

`default_nettype wire

// ----- src/tlb_chan_if.sv -----
// Valid/ready channel carrying one payload beat of type T.
// Instanced with tlbf_pkg::req_t and tlbf_pkg::rsp_t.
`default_nettype none

interface tlb_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- src/tlb_fifo_fully_associative.sv -----
// Fully associative translation buffer with FIFO replacement.
// Depends on tlbf_pkg and tlb_chan_if.
//
// Usage:
//   req carries one request beat (lookup, fill or invalidate by virtual page);
//   rsp carries one result beat per request: hit flag, physical address and
//   the running lookup and miss counters.
//   A request is first held in an input register; the lookup, fill or
//   invalidate is done against all entries from that register and lands in
//   the result register, from which rsp presents it.
//   One request is taken every cycle while rsp does not stall; the entries
//   compare against all ENTRIES tags in parallel.
//   When rsp stalls, the result register holds and the input register takes
//   one more beat; req.ready drops once both are full.
//   Synchronous reset clears all valid bits, the replacement cursor and both
//   counters; the block is ready for requests as soon as reset is released.
//   Entries compare in parallel; the lowest-numbered match answers, a fill
//   without a match takes the lowest free entry, else the cursor entry.
`default_nettype none

module tlb_fifo_fully_associative #(
  parameter int ENTRIES    = tlbf_pkg::ENTRIES_DEFAULT,
  parameter int PAGE_BYTES = tlbf_pkg::PAGE_BYTES_DEFAULT,
  parameter int PAGE_BITS  = tlbf_pkg::PAGE_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  tlb_chan_if.sink    req,
  tlb_chan_if.source  rsp
);

  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PW       = (PAGE_BITS < tlbf_pkg::PAGE_W) ? PAGE_BITS : tlbf_pkg::PAGE_W;
  localparam int OFF_BITS = $clog2(PAGE_BYTES);
  localparam logic [tlbf_pkg::OFF_W-1:0] OFF_MASK =
    tlbf_pkg::OFF_W'((64'(1) << OFF_BITS) - 64'(1));
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  logic                           stg_valid;
  tlbf_pkg::req_t                 stg;
  logic                           out_valid;
  tlbf_pkg::rsp_t                 out;
  tlbf_pkg::rsp_t                 out_next;
  logic                           advance;

  logic [ENTRIES-1:0]             valid;
  logic [PW-1:0]                  vpage [ENTRIES];
  logic [PW-1:0]                  ppage [ENTRIES];
  logic [IDX_W-1:0]               cursor;
  logic [tlbf_pkg::CNT_W-1:0]     lookups;
  logic [tlbf_pkg::CNT_W-1:0]     misses;
  logic [tlbf_pkg::CNT_W-1:0]     lookups_next;
  logic [tlbf_pkg::CNT_W-1:0]     misses_next;

  logic [PW-1:0]                  vp;
  logic [PW-1:0]                  pp;
  logic [tlbf_pkg::OFF_W-1:0]     off;
  logic [ENTRIES-1:0]             match;
  logic [ENTRIES-1:0]             match_low;
  logic [ENTRIES-1:0]             free_low;
  logic [ENTRIES-1:0]             wr_sel;
  logic                           any_match;
  logic                           any_free;
  logic [PW-1:0]                  hit_pp;
  logic [63:0]                    addr_wide;
  logic                           do_lookup;
  logic                           do_fill;
  logic                           do_inval;
  logic                           do_replace;

  assign advance   = stg_valid && (!out_valid || rsp.ready);
  assign req.ready = !stg_valid || advance;
  assign rsp.valid   = out_valid;
  assign rsp.payload = out;

  assign vp  = stg.virt_page[PW-1:0];
  assign pp  = stg.phys_page[PW-1:0];
  assign off = stg.page_offset & OFF_MASK;

  assign do_lookup = advance && (stg.action == tlbf_pkg::ACT_LOOKUP);
  assign do_fill   = advance && (stg.action == tlbf_pkg::ACT_FILL);
  assign do_inval  = advance && (stg.action == tlbf_pkg::ACT_INVAL);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid[i] && (vpage[i] == vp);
    end
  end

  assign match_low = match & (~match + ENTRIES'(1));
  assign free_low  = ~valid & (valid + ENTRIES'(1));
  assign any_match = |match;
  assign any_free  = ~&valid;
  assign do_replace = do_fill && !any_match && !any_free;

  always_comb begin
    if (any_match) begin
      wr_sel = match_low;
    end else if (any_free) begin
      wr_sel = free_low;
    end else begin
      wr_sel = ENTRIES'(1) << cursor;
    end
  end

  always_comb begin
    hit_pp = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_pp = hit_pp | (match_low[i] ? ppage[i] : '0);
    end
  end

  assign addr_wide = (64'(hit_pp) << OFF_BITS) | 64'(off);

  assign lookups_next = do_lookup ? lookups + 1'b1 : lookups;
  assign misses_next  = (do_lookup && !any_match) ? misses + 1'b1 : misses;

  always_comb begin
    out_next              = '0;
    out_next.access_count = lookups_next;
    out_next.miss_count   = misses_next;
    if (stg.action == tlbf_pkg::ACT_LOOKUP && any_match) begin
      out_next.hit       = 1'b1;
      out_next.phys_addr = addr_wide[tlbf_pkg::ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
      out_valid <= 1'b0;
      valid     <= '0;
      cursor    <= '0;
      lookups   <= '0;
      misses    <= '0;
    end else begin
      if (req.ready) begin
        stg_valid <= req.valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      lookups <= lookups_next;
      misses  <= misses_next;
      if (do_replace) begin
        cursor <= (cursor == LAST_IDX) ? '0 : cursor + 1'b1;
      end
      if (do_fill) begin
        valid <= valid | wr_sel;
      end else if (do_inval) begin
        valid <= valid & ~match;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      stg <= req.payload;
    end
    if (advance) begin
      out <= out_next;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (do_fill && wr_sel[i]) begin
        ppage[i] <= pp;
        if (!any_match) begin
          vpage[i] <= vp;
        end
      end
    end
  end

endmodule

`default_nettype wire
